FILE: sv/dtwr_pkg.sv
// Shared types, constants and tag helpers for the DS-TWR initiator sequencer.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps
`default_nettype none

package dtwr_pkg;

  // Field widths
  localparam int STAMP_BITS = 40;
  localparam int SLOTS      = 3;
  localparam int SLOT_BITS  = 2;
  localparam int ID_BITS    = 4;
  localparam int BYTE_BITS  = 8;
  localparam int OP_BITS    = 3;

  // Frame tags
  localparam logic [BYTE_BITS-1:0] TAG_POLL  = 8'h10;
  localparam logic [BYTE_BITS-1:0] TAG_FINAL = 8'h20;
  localparam logic [BYTE_BITS-1:0] TAG_RESP  = 8'h0A;

  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [ID_BITS-1:0]    anchor_id_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [BYTE_BITS-1:0]  tag_t;

  // Event codes
  typedef enum logic [OP_BITS-1:0] {
    OP_START    = 3'd0,
    OP_TX_DONE  = 3'd1,
    OP_RX_DONE  = 3'd2,
    OP_RX_ERROR = 3'd3,
    OP_TIMEOUT  = 3'd4
  } opcode_t;

  // Exchange phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_POLL_TX  = 3'd1,
    PH_RESP     = 3'd2,
    PH_FINAL_TX = 3'd3,
    PH_REPORT   = 3'd4
  } phase_t;

  // One event as it sits in the input register
  typedef struct packed {
    logic [OP_BITS-1:0] opcode;
    stamp_t             tx_stamp;
    stamp_t             rx_stamp;
    tag_t               rx_first_byte;
    stamp_t             remote_t2;
    stamp_t             remote_t3;
    stamp_t             remote_t6;
  } in_item_t;

  // One result as it sits in the output register
  typedef struct packed {
    logic   send_valid;
    tag_t   send_byte;
    logic   rx_enable;
    logic   rx_reset;
    stamp_t round_master;
    stamp_t round_slave;
    stamp_t reply_master;
    stamp_t reply_slave;
    logic   result_valid;
    slot_t  slot;
    logic   cycle_complete;
    logic   release_turn;
  } out_item_t;

  function automatic tag_t poll_tag(input anchor_id_t id);
    poll_tag = TAG_POLL | {4'h0, id};
  endfunction

  function automatic tag_t final_tag(input anchor_id_t id);
    final_tag = TAG_FINAL | {4'h0, id};
  endfunction

  // Expected response tag: id in the high nibble, 0xA in the low one
  function automatic tag_t resp_tag(input anchor_id_t id);
    resp_tag = TAG_RESP | {id, 4'h0};
  endfunction

endpackage

`default_nettype wire

FILE: sv/dtwr_ifs.sv
// Valid/ready channel interfaces for event input and result output.
// Depends on dtwr_pkg for field types.
`timescale 1ns / 1ps
`default_nettype none

interface dtwr_in_if;
  logic                            valid;
  logic                            ready;
  logic [dtwr_pkg::OP_BITS-1:0]    opcode;
  dtwr_pkg::stamp_t                tx_stamp;
  dtwr_pkg::stamp_t                rx_stamp;
  dtwr_pkg::tag_t                  rx_first_byte;
  dtwr_pkg::stamp_t                remote_t2;
  dtwr_pkg::stamp_t                remote_t3;
  dtwr_pkg::stamp_t                remote_t6;

  modport source (
    output valid, opcode, tx_stamp, rx_stamp, rx_first_byte,
           remote_t2, remote_t3, remote_t6,
    input  ready
  );

  modport sink (
    input  valid, opcode, tx_stamp, rx_stamp, rx_first_byte,
           remote_t2, remote_t3, remote_t6,
    output ready
  );
endinterface

interface dtwr_out_if;
  logic                  valid;
  logic                  ready;
  logic                  send_valid;
  dtwr_pkg::tag_t        send_byte;
  logic                  rx_enable;
  logic                  rx_reset;
  dtwr_pkg::stamp_t      round_master;
  dtwr_pkg::stamp_t      round_slave;
  dtwr_pkg::stamp_t      reply_master;
  dtwr_pkg::stamp_t      reply_slave;
  logic                  result_valid;
  dtwr_pkg::slot_t       slot;
  logic                  cycle_complete;
  logic                  release_turn;

  modport source (
    output valid, send_valid, send_byte, rx_enable, rx_reset,
           round_master, round_slave, reply_master, reply_slave,
           result_valid, slot, cycle_complete, release_turn,
    input  ready
  );

  modport sink (
    input  valid, send_valid, send_byte, rx_enable, rx_reset,
           round_master, round_slave, reply_master, reply_slave,
           result_valid, slot, cycle_complete, release_turn,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/ds_twr_initiator_sequencer.sv
// DS-TWR initiator sequencer, top level.
// Path: an event is held in the input register, then its result in the result register.
// One event per cycle unless stalled; phase, stamps and slot counter update as it is taken.
// Stall: the input takes a new event whenever the result register is free or being drained.
// Reset (rst_n low, synchronous): phase idle, T1/T4/T5 and slot count zero, anchor id 1,
// both channel registers empty. Depends on dtwr_pkg, dtwr_ifs and the dtwr_* submodules.
`timescale 1ns / 1ps
`default_nettype none

module ds_twr_initiator_sequencer (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire dtwr_pkg::anchor_id_t  cfg_wdata,
  dtwr_in_if.sink                    in_chan,
  dtwr_out_if.source                 out_chan
);

  dtwr_pkg::in_item_t  item;
  dtwr_pkg::out_item_t res;
  logic                item_valid;
  logic                can_load;
  logic                fire;

  // Event moves from input register to result register
  assign fire = item_valid && can_load;

  dtwr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (fire),
    .item       (item),
    .item_valid (item_valid)
  );

  dtwr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .res       (res)
  );

  dtwr_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .res      (res),
    .can_load (can_load),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

FILE: sv/dtwr_in_reg.sv
// Input register: captures one event transaction and holds it until the core takes it.
// Depends on dtwr_pkg and dtwr_in_if.
`timescale 1ns / 1ps
`default_nettype none

module dtwr_in_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  dtwr_in_if.sink                 in_chan,
  input  wire logic               take,
  output dtwr_pkg::in_item_t      item,
  output logic                    item_valid
);

  logic               valid_r;
  logic               valid_nxt;
  dtwr_pkg::in_item_t item_r;
  logic               accept;

  // Free slot, or the held event leaves this cycle
  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.opcode        <= in_chan.opcode;
      item_r.tx_stamp      <= in_chan.tx_stamp;
      item_r.rx_stamp      <= in_chan.rx_stamp;
      item_r.rx_first_byte <= in_chan.rx_first_byte;
      item_r.remote_t2     <= in_chan.remote_t2;
      item_r.remote_t3     <= in_chan.remote_t3;
      item_r.remote_t6     <= in_chan.remote_t6;
    end
  end

  assign item       = item_r;
  assign item_valid = valid_r;

endmodule

`default_nettype wire

FILE: sv/dtwr_core.sv
// Exchange sequencer: phase machine, latched T1/T4/T5, slot counter, anchor id register
// and the combinational result logic. Depends on dtwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtwr_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire dtwr_pkg::anchor_id_t  cfg_wdata,
  input  wire logic                  fire,
  input  wire dtwr_pkg::in_item_t    item,
  output dtwr_pkg::out_item_t        res
);

  dtwr_pkg::phase_t     phase_r, phase_nxt;
  dtwr_pkg::stamp_t     t1_r, t1_nxt;
  dtwr_pkg::stamp_t     t4_r, t4_nxt;
  dtwr_pkg::stamp_t     t5_r, t5_nxt;
  dtwr_pkg::slot_t      slot_r, slot_nxt;
  dtwr_pkg::anchor_id_t anchor_id_r;

  logic                          resp_match;
  logic                          report_ok;
  logic [dtwr_pkg::SLOT_BITS:0]  slot_inc;
  logic                          slot_wrap;

  // Tag check and report sanity check
  assign resp_match = (item.rx_first_byte == dtwr_pkg::resp_tag(anchor_id_r));
  assign report_ok  = (item.remote_t6 >= item.remote_t2) && (t5_r >= t1_r);

  // Slot counter advance with wrap after the last slot
  assign slot_inc  = {1'b0, slot_r} + (dtwr_pkg::SLOT_BITS+1)'(1);
  assign slot_wrap = slot_inc >= (dtwr_pkg::SLOT_BITS+1)'(dtwr_pkg::SLOTS);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    t1_nxt    = t1_r;
    t4_nxt    = t4_r;
    t5_nxt    = t5_r;
    slot_nxt  = slot_r;
    if (fire) begin
      case (item.opcode)
        dtwr_pkg::OP_START: begin
          if (phase_r == dtwr_pkg::PH_IDLE) begin
            phase_nxt = dtwr_pkg::PH_POLL_TX;
          end
        end
        dtwr_pkg::OP_TX_DONE: begin
          if (phase_r == dtwr_pkg::PH_POLL_TX) begin
            t1_nxt    = item.tx_stamp;
            phase_nxt = dtwr_pkg::PH_RESP;
          end else if (phase_r == dtwr_pkg::PH_FINAL_TX) begin
            t5_nxt    = item.tx_stamp;
            phase_nxt = dtwr_pkg::PH_REPORT;
          end
        end
        dtwr_pkg::OP_RX_DONE: begin
          if (phase_r == dtwr_pkg::PH_RESP) begin
            if (resp_match) begin
              t4_nxt    = item.rx_stamp;
              phase_nxt = dtwr_pkg::PH_FINAL_TX;
            end else begin
              phase_nxt = dtwr_pkg::PH_POLL_TX;
            end
          end else if (phase_r == dtwr_pkg::PH_REPORT) begin
            if (report_ok) begin
              slot_nxt  = slot_wrap ? '0 : slot_inc[dtwr_pkg::SLOT_BITS-1:0];
              phase_nxt = dtwr_pkg::PH_IDLE;
            end else begin
              phase_nxt = dtwr_pkg::PH_POLL_TX;
            end
          end
        end
        dtwr_pkg::OP_RX_ERROR: begin
          if (phase_r inside {dtwr_pkg::PH_RESP, dtwr_pkg::PH_REPORT}) begin
            phase_nxt = dtwr_pkg::PH_POLL_TX;
          end
        end
        dtwr_pkg::OP_TIMEOUT: begin
          if (phase_r inside {dtwr_pkg::PH_RESP, dtwr_pkg::PH_REPORT}) begin
            phase_nxt = dtwr_pkg::PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result for the event in the input register
  always_comb begin
    res = '0;
    case (item.opcode)
      dtwr_pkg::OP_START: begin
        if (phase_r == dtwr_pkg::PH_IDLE) begin
          res.send_valid = 1'b1;
          res.send_byte  = dtwr_pkg::poll_tag(anchor_id_r);
        end
      end
      dtwr_pkg::OP_TX_DONE: begin
        if (phase_r inside {dtwr_pkg::PH_POLL_TX, dtwr_pkg::PH_FINAL_TX}) begin
          res.rx_enable = 1'b1;
        end
      end
      dtwr_pkg::OP_RX_DONE: begin
        if (phase_r == dtwr_pkg::PH_RESP) begin
          res.send_valid = 1'b1;
          res.send_byte  = resp_match ? dtwr_pkg::final_tag(anchor_id_r)
                                      : dtwr_pkg::poll_tag(anchor_id_r);
        end else if (phase_r == dtwr_pkg::PH_REPORT) begin
          if (report_ok) begin
            res.round_master   = t4_r - t1_r;
            res.round_slave    = item.remote_t6 - item.remote_t3;
            res.reply_master   = t5_r - t4_r;
            res.reply_slave    = item.remote_t3 - item.remote_t2;
            res.result_valid   = 1'b1;
            res.slot           = slot_r;
            res.cycle_complete = slot_wrap;
            res.release_turn   = 1'b1;
          end else begin
            res.send_valid = 1'b1;
            res.send_byte  = dtwr_pkg::poll_tag(anchor_id_r);
          end
        end
      end
      dtwr_pkg::OP_RX_ERROR: begin
        if (phase_r inside {dtwr_pkg::PH_RESP, dtwr_pkg::PH_REPORT}) begin
          res.rx_reset   = 1'b1;
          res.send_valid = 1'b1;
          res.send_byte  = dtwr_pkg::poll_tag(anchor_id_r);
        end
      end
      dtwr_pkg::OP_TIMEOUT: begin
        if (phase_r inside {dtwr_pkg::PH_RESP, dtwr_pkg::PH_REPORT}) begin
          res.release_turn = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dtwr_pkg::PH_IDLE;
      t1_r    <= '0;
      t4_r    <= '0;
      t5_r    <= '0;
      slot_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      t1_r    <= t1_nxt;
      t4_r    <= t4_nxt;
      t5_r    <= t5_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // Anchor id register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_id_r <= dtwr_pkg::anchor_id_t'(1);
    end else if (cfg_we) begin
      anchor_id_r <= cfg_wdata;
    end
  end

`ifndef SYNTH
  // Only a consumed event moves the phase
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(phase_r))
    else $error("phase changed without an event");

  // A completed measurement always ends the exchange
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.result_valid |=> phase_r == dtwr_pkg::PH_IDLE)
    else $error("measurement did not return to idle");

  // A transmit request is always followed by waiting for its transmit done
  a_send_waits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.send_valid |=>
      phase_r == dtwr_pkg::PH_POLL_TX || phase_r == dtwr_pkg::PH_FINAL_TX)
    else $error("send without transmit wait");

  // Wrap only on the last slot of a measurement
  a_wrap_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res.cycle_complete |->
      res.result_valid && res.slot == dtwr_pkg::slot_t'(dtwr_pkg::SLOTS - 1))
    else $error("cycle_complete off the last slot");
`endif

endmodule

`default_nettype wire

FILE: sv/dtwr_out_reg.sv
// Result register: holds one result transaction until the sink takes it.
// Depends on dtwr_pkg and dtwr_out_if.
`timescale 1ns / 1ps
`default_nettype none

module dtwr_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire dtwr_pkg::out_item_t  res,
  output logic                      can_load,
  dtwr_out_if.source                out_chan
);

  logic                valid_r;
  logic                valid_nxt;
  dtwr_pkg::out_item_t res_r;

  // Empty, or the held result leaves this cycle
  assign can_load = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  // Drive the channel
  assign out_chan.valid          = valid_r;
  assign out_chan.send_valid     = res_r.send_valid;
  assign out_chan.send_byte      = res_r.send_byte;
  assign out_chan.rx_enable      = res_r.rx_enable;
  assign out_chan.rx_reset       = res_r.rx_reset;
  assign out_chan.round_master   = res_r.round_master;
  assign out_chan.round_slave    = res_r.round_slave;
  assign out_chan.reply_master   = res_r.reply_master;
  assign out_chan.reply_slave    = res_r.reply_slave;
  assign out_chan.result_valid   = res_r.result_valid;
  assign out_chan.slot           = res_r.slot;
  assign out_chan.cycle_complete = res_r.cycle_complete;
  assign out_chan.release_turn   = res_r.release_turn;

endmodule

`default_nettype wire
